@@ hdl/hslcc_pkg.sv @@
package hslcc_pkg;

  // Width of the divisor and remainder in every divider lane (six times delta fits).
  localparam int unsigned DivW = 11;

  // Lightness bounds, tested exactly on max + min of the channels.
  localparam logic [8:0] SumHi  = 9'd408;
  localparam logic [8:0] SumLo  = 9'd102;
  localparam logic [8:0] SumMid = 9'd255;
  localparam logic [8:0] SumTop = 9'd510;

  // Per-pixel data that rides alongside the divider lanes.
  typedef struct packed {
    logic [8:0] sum;         // max + min of the channels
    logic       forced;      // lightness replaced by one half
    logic       grey;        // zero delta
    logic       sat_one;     // saturation is exactly one
    logic       sum_lt_mid;  // sum below 255
  } side_t;

  // Piece of the hue-to-channel rule.
  typedef enum logic [1:0] {
    SegRise,
    SegTop,
    SegFall,
    SegBottom
  } seg_e;

endpackage

@@ hdl/hslcc_div_cell.sv @@
module hslcc_div_cell #(
  parameter int DW = 11,
  parameter int QW = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] div_i,
  input  logic [QW-1:0] quo_i,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] div_o,
  output logic [QW-1:0] quo_o
);

  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_d;
  logic [QW-1:0] quo_d;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] div_q;
  logic [QW-1:0] quo_q;

  // One restoring step: the remainder stays below the divisor, so the
  // difference always fits back into DW bits.
  always_comb begin
    trial = {rem_i, 1'b0};
    ge    = trial >= {1'b0, div_i};
    rem_d = ge ? DW'(trial - {1'b0, div_i}) : trial[DW-1:0];
    quo_d = {quo_i[QW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      div_q <= div_i;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign div_o = div_q;
  assign quo_o = quo_q;

endmodule

@@ hdl/hslcc_chan.sv @@
module hslcc_chan #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS-1:0] hue_i,
  input  logic                 grey_i,
  input  logic [7:0]           grey_byte_i,
  input  logic [FRAC_BITS+1:0] v1_i,
  input  logic [FRAC_BITS+1:0] v2_i,
  output logic [7:0]           byte_o
);

  localparam int VW = FRAC_BITS + 2;
  localparam logic [FRAC_BITS+2:0] OneW  = (FRAC_BITS+3)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS+2:0] FourW = (FRAC_BITS+3)'(4) << FRAC_BITS;
  localparam logic [FRAC_BITS:0]   OneH  = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS+1:0] TwoH  = (FRAC_BITS+2)'(2) << FRAC_BITS;
  localparam logic [VW+9:0]        HalfB = (VW+10)'(1) << (FRAC_BITS-1);

  logic [FRAC_BITS+2:0] h6;
  logic [FRAC_BITS:0]   h2;
  logic [FRAC_BITS+1:0] h3;
  hslcc_pkg::seg_e      seg_d;
  logic [FRAC_BITS:0]   fac_d;

  hslcc_pkg::seg_e      seg1_q, seg2_q;
  logic [FRAC_BITS:0]   fac1_q;
  logic [2:0]           grey_q;
  logic [7:0]           greyb1_q, greyb2_q, greyb3_q;

  logic [VW-1:0]           diff;
  logic [VW+FRAC_BITS:0]   prod_full;
  logic [VW-1:0]           prod2_q;
  logic [VW-1:0]           v1_2_q, v2_2_q;
  logic [VW:0]             val_d, val3_q;
  logic [VW+9:0]           scaled;
  logic [7:0]              byte_d, byte_q;

  // Piece selection on the hue.
  always_comb begin
    h6 = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};
    h2 = {hue_i, 1'b0};
    h3 = {1'b0, hue_i, 1'b0} + {2'b00, hue_i};
    seg_d = hslcc_pkg::SegBottom;
    fac_d = '0;
    if (h6 < OneW) begin
      seg_d = hslcc_pkg::SegRise;
      fac_d = h6[FRAC_BITS:0];
    end else if (h2 < OneH) begin
      seg_d = hslcc_pkg::SegTop;
    end else if (h3 < TwoH) begin
      seg_d = hslcc_pkg::SegFall;
      fac_d = (FRAC_BITS+1)'(FourW - h6);
    end
  end

  always_comb begin
    diff      = v2_i - v1_i;
    prod_full = diff * fac1_q;
  end

  always_comb begin
    unique case (seg2_q)
      hslcc_pkg::SegRise, hslcc_pkg::SegFall: val_d = {1'b0, v1_2_q} + {1'b0, prod2_q};
      hslcc_pkg::SegTop:                      val_d = {1'b0, v2_2_q};
      default:                                val_d = {1'b0, v1_2_q};
    endcase
  end

  // Scale to a byte with rounding half up, saturating at 255; a grey pixel takes the grey byte.
  always_comb begin
    scaled = {1'b0, val3_q, 8'd0} - {9'd0, val3_q} + HalfB;
    if (grey_q[2]) begin
      byte_d = greyb3_q;
    end else if (scaled[VW+9:FRAC_BITS+8] != '0) begin
      byte_d = 8'hFF;
    end else begin
      byte_d = scaled[FRAC_BITS+7:FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg1_q   <= seg_d;
      fac1_q   <= fac_d;
      seg2_q   <= seg1_q;
      prod2_q  <= prod_full[VW+FRAC_BITS-1:FRAC_BITS];
      v1_2_q   <= v1_i;
      v2_2_q   <= v2_i;
      val3_q   <= val_d;
      byte_q   <= byte_d;
      grey_q   <= {grey_q[1:0], grey_i};
      greyb1_q <= grey_byte_i;
      greyb2_q <= greyb1_q;
      greyb3_q <= greyb2_q;
    end
  end

  assign byte_o = byte_q;

endmodule

@@ hdl/hsl_contrast_colour.sv @@
// Contrasting colour of an 8-bit RGB pixel: hue turned by half a turn,
// extreme lightness pulled to one half, then converted back to RGB.
//
// Input channel: in_valid_i / in_ready_o with red_in_i, green_in_i and
// blue_in_i. Output channel: out_valid_o / out_ready_i with red_out_o,
// green_out_o and blue_out_o. One result leaves for every transaction.
//
// One pixel is taken every cycle while the skid register is empty. The
// two divisions (saturation, hue) run side by side through a row of
// FRAC_BITS divider cells, one quotient bit per cell; that row sets the
// latency. Lightness is formed from the sum at the end of the row. The
// back end is six further stages; two of them hold a multiply.
//
// Reset clears all valid flags; the pipeline is empty afterward and
// ready at once. When the receiver stalls, the waiting result moves to
// a skid register and one more transaction is still taken; the whole
// pipeline then holds until the skid register is emptied.
module hsl_contrast_colour #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o
);

  localparam int DW   = hslcc_pkg::DivW;
  localparam int NST  = FRAC_BITS + 8;
  localparam int VW   = FRAC_BITS + 2;
  localparam int LRep = (FRAC_BITS + 6) / 8;
  localparam logic [FRAC_BITS:0]   One   = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0]   Half  = (FRAC_BITS+1)'(1) << (FRAC_BITS-1);
  localparam logic [FRAC_BITS-1:0] Third = FRAC_BITS'((1 << FRAC_BITS) / 3);

  logic           en;
  logic [NST-1:0] vld_q;
  logic           s_vld_q;
  logic [7:0]     s_red_q, s_green_q, s_blue_q;

  // Front stage: extremes and hue numerator pieces.
  logic [7:0]        mx, mn;
  logic [3:0]        k_d;
  logic signed [8:0] dd_d;
  logic [8:0]        p_sum_q;
  logic [7:0]        p_delta_q;
  logic [3:0]        p_k_q;
  logic signed [8:0] p_dd_q;

  // Lane set-up stage.
  logic [11:0]              kd;
  logic signed [13:0]       num_s;
  logic [11:0]              num, m1, m2;
  logic [10:0]              six;
  logic [7:0]               d_div;
  hslcc_pkg::side_t         side_d;
  logic [DW-1:0]            s1_rem_q [2];
  logic [DW-1:0]            s1_div_q [2];
  hslcc_pkg::side_t         side_q [FRAC_BITS+1];

  logic [DW-1:0]        rem_w [2][FRAC_BITS+1];
  logic [DW-1:0]        div_w [2][FRAC_BITS+1];
  logic [FRAC_BITS-1:0] quo_w [2][FRAC_BITS+1];

  // Back end.
  logic [8:0]             l_sum;
  logic                   l_hi;
  logic [7:0]             l_rem;
  logic [8*LRep-1:0]      l_rep;
  logic [FRAC_BITS:0]     l_ceil;
  logic [FRAC_BITS:0]     a_l_q, a_s_q;
  logic [FRAC_BITS-1:0]   a_h_q;
  logic                   a_grey_q, a_lt_q;
  logic [2*FRAC_BITS+1:0] ls_prod;
  logic [FRAC_BITS+8:0]   g255;
  logic [FRAC_BITS:0]     hr_sum, hb_sum;
  logic [FRAC_BITS-1:0]   hr_d, hb_d;
  logic [FRAC_BITS:0]     b_p_q, b_l_q, b_s_q;
  logic                   b_lo_q, b_grey_q;
  logic [7:0]             b_greyb_q;
  logic [FRAC_BITS-1:0]   b_hr_q, b_hg_q, b_hb_q;
  logic [VW-1:0]          v2_d, v1_d, twol;
  logic [VW-1:0]          c_v1_q, c_v2_q;
  logic [7:0]             red_w, green_w, blue_w;

  assign en         = ~s_vld_q;
  assign in_ready_o = en;

  always_comb begin
    mx = red_in_i;
    mn = red_in_i;
    if (green_in_i > mx) mx = green_in_i;
    if (blue_in_i > mx) mx = blue_in_i;
    if (green_in_i < mn) mn = green_in_i;
    if (blue_in_i < mn) mn = blue_in_i;
    // Hue numerator is k*delta + diff, with the half-turn folded into k.
    if (red_in_i == mx) begin
      k_d  = 4'd9;
      dd_d = $signed({1'b0, green_in_i}) - $signed({1'b0, blue_in_i});
    end else if (green_in_i == mx) begin
      k_d  = 4'd11;
      dd_d = $signed({1'b0, blue_in_i}) - $signed({1'b0, red_in_i});
    end else begin
      k_d  = 4'd13;
      dd_d = $signed({1'b0, red_in_i}) - $signed({1'b0, green_in_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_sum_q   <= {1'b0, mx} + {1'b0, mn};
      p_delta_q <= mx - mn;
      p_k_q     <= k_d;
      p_dd_q    <= dd_d;
    end
  end

  always_comb begin
    kd    = {8'd0, p_k_q} * {4'd0, p_delta_q};
    num_s = $signed({2'b00, kd}) + $signed({{5{p_dd_q[8]}}, p_dd_q});
    num   = num_s[11:0];
    six   = {1'b0, p_delta_q, 2'b00} + {2'b00, p_delta_q, 1'b0};
    // The numerator lies between 8 and 14 times delta: at most two subtractions.
    m1    = num - {1'b0, six};
    m2    = (m1 >= {1'b0, six}) ? m1 - {1'b0, six} : m1;
    d_div = (p_sum_q <= hslcc_pkg::SumMid) ? p_sum_q[7:0]
                                           : 8'(hslcc_pkg::SumTop - p_sum_q);
    side_d.sum        = p_sum_q;
    side_d.forced     = (p_sum_q > hslcc_pkg::SumHi) || (p_sum_q < hslcc_pkg::SumLo);
    side_d.grey       = (p_delta_q == 8'd0);
    side_d.sat_one    = (p_delta_q == d_div);
    side_d.sum_lt_mid = (p_sum_q < hslcc_pkg::SumMid);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_rem_q[0] <= side_d.sat_one ? '0 : DW'(p_delta_q);
      s1_div_q[0] <= DW'(d_div);
      s1_rem_q[1] <= m2[DW-1:0];
      s1_div_q[1] <= six;
      side_q[0]   <= side_d;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign rem_w[l][0] = s1_rem_q[l];
    assign div_w[l][0] = s1_div_q[l];
    assign quo_w[l][0] = '0;
    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_cell
      hslcc_div_cell #(
        .DW(DW),
        .QW(FRAC_BITS)
      ) u_cell (
        .clk_i(clk_i),
        .en_i (en),
        .rem_i(rem_w[l][k]),
        .div_i(div_w[l][k]),
        .quo_i(quo_w[l][k]),
        .rem_o(rem_w[l][k+1]),
        .div_o(div_w[l][k+1]),
        .quo_o(quo_w[l][k+1])
      );
    end
  end

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // Lightness is sum / 510 rounded up. Writing sum = 255*a + b, the binary
  // expansion of b / 255 is the byte b repeated, so the quotient is wiring.
  // The division is exact only when sum is a multiple of 255.
  always_comb begin
    l_sum  = side_q[FRAC_BITS].sum;
    l_hi   = (l_sum >= hslcc_pkg::SumMid);
    l_rem  = l_hi ? 8'(l_sum - hslcc_pkg::SumMid) : l_sum[7:0];
    l_rep  = {LRep{l_rem}};
    l_ceil = (l_hi ? Half : '0) + {2'b00, l_rep[8*LRep-1 -: FRAC_BITS-1]} +
             (FRAC_BITS+1)'(l_sum != hslcc_pkg::SumMid);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_l_q    <= side_q[FRAC_BITS].forced ? Half : l_ceil;
      a_s_q    <= {side_q[FRAC_BITS].sat_one, quo_w[0][FRAC_BITS]};
      a_h_q    <= quo_w[1][FRAC_BITS];
      a_grey_q <= side_q[FRAC_BITS].grey;
      a_lt_q   <= side_q[FRAC_BITS].sum_lt_mid;
    end
  end

  always_comb begin
    ls_prod = a_l_q * a_s_q;
    g255    = {a_l_q, 8'd0} - {8'd0, a_l_q};
    hr_sum  = {1'b0, a_h_q} + {1'b0, Third};
    hr_d    = (hr_sum >= One) ? FRAC_BITS'(hr_sum - One) : hr_sum[FRAC_BITS-1:0];
    hb_sum  = {1'b0, a_h_q} + One - {1'b0, Third};
    hb_d    = (a_h_q >= Third) ? (a_h_q - Third) : hb_sum[FRAC_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_p_q     <= ls_prod[2*FRAC_BITS:FRAC_BITS];
      b_l_q     <= a_l_q;
      b_s_q     <= a_s_q;
      b_lo_q    <= a_lt_q && (a_l_q < Half);
      b_grey_q  <= a_grey_q;
      b_greyb_q <= g255[FRAC_BITS+7:FRAC_BITS];
      b_hr_q    <= hr_d;
      b_hg_q    <= a_h_q;
      b_hb_q    <= hb_d;
    end
  end

  always_comb begin
    if (b_lo_q) begin
      v2_d = {1'b0, b_l_q} + {1'b0, b_p_q};
    end else begin
      v2_d = {1'b0, b_l_q} + {1'b0, b_s_q} - {1'b0, b_p_q};
    end
    twol = {b_l_q, 1'b0};
    v1_d = (twol > v2_d) ? twol - v2_d : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_v1_q <= v1_d;
      c_v2_q <= v2_d;
    end
  end

  hslcc_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk_i      (clk_i),
    .en_i       (en),
    .hue_i      (b_hr_q),
    .grey_i     (b_grey_q),
    .grey_byte_i(b_greyb_q),
    .v1_i       (c_v1_q),
    .v2_i       (c_v2_q),
    .byte_o     (red_w)
  );

  hslcc_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk_i      (clk_i),
    .en_i       (en),
    .hue_i      (b_hg_q),
    .grey_i     (b_grey_q),
    .grey_byte_i(b_greyb_q),
    .v1_i       (c_v1_q),
    .v2_i       (c_v2_q),
    .byte_o     (green_w)
  );

  hslcc_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk_i      (clk_i),
    .en_i       (en),
    .hue_i      (b_hb_q),
    .grey_i     (b_grey_q),
    .grey_byte_i(b_greyb_q),
    .v1_i       (c_v1_q),
    .v2_i       (c_v2_q),
    .byte_o     (blue_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // The last stage holds the oldest result; on a stall it moves to the
  // skid register so the pipeline can take one more step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else if (s_vld_q) begin
      if (out_ready_i) s_vld_q <= 1'b0;
    end else if (vld_q[NST-1] && !out_ready_i) begin
      s_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!s_vld_q && vld_q[NST-1] && !out_ready_i) begin
      s_red_q   <= red_w;
      s_green_q <= green_w;
      s_blue_q  <= blue_w;
    end
  end

  assign out_valid_o = s_vld_q | vld_q[NST-1];
  assign red_out_o   = s_vld_q ? s_red_q   : red_w;
  assign green_out_o = s_vld_q ? s_green_q : green_w;
  assign blue_out_o  = s_vld_q ? s_blue_q  : blue_w;

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_vld_q && !out_ready_i |=> s_vld_q)
    else $error("skid register dropped a stalled transaction");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_vld_q) |-> $past(vld_q[NST-1] && !out_ready_i))
    else $error("skid register filled without a stalled result");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_vld_q |=> $stable(vld_q))
    else $error("pipeline moved while the skid register was full");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_vld_q && out_ready_i |=> !s_vld_q)
    else $error("skid register kept a delivered transaction");

endmodule
